/* hw/rtl/cbframe_pkg.sv */
// ----------------------------------------------------------------------------
// cbframe_pkg
// Shared types, codes and character helpers for the chunk line framer.
// ----------------------------------------------------------------------------
package cbframe_pkg;

  localparam int          CHUNK_BYTES_DEF = 32;
  localparam logic [3:0]  VERSION_RESET   = 4'd1;
  localparam logic [31:0] CRC_ONES        = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;

  localparam logic        MODE_START = 1'b0;
  localparam logic        MODE_DATA  = 1'b1;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_BAD_START = 2'd1;
  localparam logic [1:0]  ST_STRAY     = 2'd2;

  localparam logic [7:0]  CH_LT    = 8'h3C;
  localparam logic [7:0]  CH_GT    = 8'h3E;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_UPPER = 8'h41;
  localparam logic [7:0]  CH_TWO   = 8'h32;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ERROR, S_DIVIDE, S_COMMIT, S_BYTE, S_CHECK,
    S_LT, S_SLASH, S_TAG, S_C1, S_VER, S_C2, S_TASK, S_C3, S_IDX,
    S_C4, S_TOT, S_C5, S_HEX, S_C6, S_B32, S_GT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    SEL_LT, SEL_SLASH, SEL_TAG, SEL_COLON, SEL_DEC, SEL_HEX, SEL_B32, SEL_GT
  } sel_t;

  typedef enum logic [1:0] {
    DSRC_VER, DSRC_TASK, DSRC_IDX, DSRC_TOT
  } dsrc_t;

  typedef struct packed {
    logic       capture;
    logic       start_msg;
    logic       set_total;
    logic       take_byte;
    logic       err_push;
    logic [1:0] err_code;
    logic       gen;
    sel_t       sel;
    logic       dec_load;
    dsrc_t      dec_src;
    logic       b32_init;
    logic       is_end;
    logic       run_last;
    logic       chunk_done;
    logic       msg_done;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic bad_start;
    logic active;
    logic div_done;
    logic need_line;
    logic last_byte;
    logic len_zero;
    logic out_free;
    logic field_done;
  } stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (CH_UPPER + {4'd0, n} - 8'd10);
  endfunction

  function automatic logic [7:0] b32_char(input logic [4:0] n);
    return (n < 5'd26) ? (CH_UPPER + {3'd0, n}) : (CH_TWO + {3'd0, n} - 8'd26);
  endfunction

  function automatic logic [7:0] tag_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h52;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h42;
      3'd3:    c = 8'h33;
      default: c = 8'h32;
    endcase
    return c;
  endfunction

  // k times the decimal weight of digit position pos
  function automatic logic [16:0] dec_mul(input logic [2:0] pos, input logic [3:0] k);
    logic [16:0] p;
    case (pos)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      default: p = 17'd10000;
    endcase
    return 17'(p * {13'd0, k});
  endfunction

endpackage

/* hw/rtl/crc32_base32_chunk_line_framer.sv */
// ----------------------------------------------------------------------------
// crc32_base32_chunk_line_framer
// Frames a byte message into text chunk lines with crc-32 and base32, then
// an end line carrying the crc-32 of the whole message.
// ----------------------------------------------------------------------------
// a data byte that closes no chunk holds the input while it is decoded and taken
// a start holds the input while the chunk total is multiplied out
// line characters come out one per cycle unless the output stalls; a decimal
// leading zero and a chunk byte fetched from memory each take a step without one
// synchronous active-high reset clears control; format_version resets to 1
module crc32_base32_chunk_line_framer import cbframe_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        mode,
  input  logic [15:0] task_id,
  input  logic [20:0] message_length,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] text_word,
  output logic [3:0]  char_count,
  output logic        line_end,
  output logic        message_end,
  output logic        last_of_run,
  output logic [1:0]  status
);

  cmd_t  cmd;
  stat_t stat;

  cbframe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  cbframe_dp #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mode           (mode),
    .task_id        (task_id),
    .message_length (message_length),
    .data_byte      (data_byte),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .text_word      (text_word),
    .char_count     (char_count),
    .line_end       (line_end),
    .message_end    (message_end),
    .last_of_run    (last_of_run),
    .status         (status),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

/* hw/rtl/cbframe_ctrl.sv */
// ----------------------------------------------------------------------------
// cbframe_ctrl
// Sequencer: decodes items and walks the fields of chunk and end lines.
// ----------------------------------------------------------------------------
module cbframe_ctrl import cbframe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   is_end, is_end_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      is_end <= 1'b0;
    end else begin
      state  <= state_next;
      is_end <= is_end_next;
    end
  end

  always_comb begin
    state_next  = state;
    is_end_next = is_end;
    case (state)
      S_IDLE:   if (item_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.mode == MODE_START) begin
          state_next = stat.bad_start ? S_ERROR : S_DIVIDE;
        end else begin
          state_next = stat.active ? S_BYTE : S_ERROR;
        end
      end
      S_ERROR:  if (stat.out_free) state_next = S_IDLE;
      S_DIVIDE: if (stat.div_done) state_next = S_COMMIT;
      S_COMMIT: begin
        is_end_next = 1'b0;
        state_next  = stat.len_zero ? S_LT : S_IDLE;
      end
      S_BYTE:   state_next = S_CHECK;
      S_CHECK: begin
        is_end_next = 1'b0;
        state_next  = stat.need_line ? S_LT : S_IDLE;
      end
      S_LT:     if (stat.field_done) state_next = is_end ? S_SLASH : S_TAG;
      S_SLASH:  if (stat.field_done) state_next = S_TAG;
      S_TAG:    if (stat.field_done) state_next = S_C1;
      S_C1:     if (stat.field_done) state_next = S_VER;
      S_VER:    if (stat.field_done) state_next = S_C2;
      S_C2:     if (stat.field_done) state_next = S_TASK;
      S_TASK:   if (stat.field_done) state_next = is_end ? S_C5 : S_C3;
      S_C3:     if (stat.field_done) state_next = S_IDX;
      S_IDX:    if (stat.field_done) state_next = S_C4;
      S_C4:     if (stat.field_done) state_next = S_TOT;
      S_TOT:    if (stat.field_done) state_next = S_C5;
      S_C5:     if (stat.field_done) state_next = S_HEX;
      S_HEX:    if (stat.field_done) state_next = is_end ? S_GT : S_C6;
      S_C6:     if (stat.field_done) state_next = S_B32;
      S_B32:    if (stat.field_done) state_next = S_GT;
      S_GT:     if (stat.field_done) state_next = S_FINISH;
      S_FINISH: begin
        if (!is_end && stat.last_byte) begin
          is_end_next = 1'b1;
          state_next  = S_LT;
        end else begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.sel        = SEL_COLON;
    cmd.dec_src    = DSRC_VER;
    cmd.is_end     = is_end;
    cmd.run_last   = is_end || !stat.last_byte;
    item_stall     = (state != S_IDLE);
    case (state)
      S_IDLE:   cmd.capture = item_valid;
      S_DECODE: cmd.start_msg = (stat.mode == MODE_START) && !stat.bad_start;
      S_ERROR: begin
        cmd.err_push = stat.out_free;
        cmd.err_code = (stat.mode == MODE_START) ? ST_BAD_START : ST_STRAY;
      end
      S_COMMIT: cmd.set_total = 1'b1;
      S_BYTE:   cmd.take_byte = 1'b1;
      S_LT:     begin cmd.gen = 1'b1; cmd.sel = SEL_LT;    end
      S_SLASH:  begin cmd.gen = 1'b1; cmd.sel = SEL_SLASH; end
      S_TAG:    begin cmd.gen = 1'b1; cmd.sel = SEL_TAG;   end
      S_C1: begin
        cmd.gen = 1'b1; cmd.dec_load = 1'b1; cmd.dec_src = DSRC_VER;
      end
      S_C2: begin
        cmd.gen = 1'b1; cmd.dec_load = 1'b1; cmd.dec_src = DSRC_TASK;
      end
      S_C3: begin
        cmd.gen = 1'b1; cmd.dec_load = 1'b1; cmd.dec_src = DSRC_IDX;
      end
      S_C4: begin
        cmd.gen = 1'b1; cmd.dec_load = 1'b1; cmd.dec_src = DSRC_TOT;
      end
      S_C5:     cmd.gen = 1'b1;
      S_C6:     begin cmd.gen = 1'b1; cmd.b32_init = 1'b1; end
      S_VER, S_TASK, S_IDX, S_TOT: begin
        cmd.gen = 1'b1; cmd.sel = SEL_DEC;
      end
      S_HEX:    begin cmd.gen = 1'b1; cmd.sel = SEL_HEX; end
      S_B32:    begin cmd.gen = 1'b1; cmd.sel = SEL_B32; end
      S_GT:     begin cmd.gen = 1'b1; cmd.sel = SEL_GT;  end
      S_FINISH: begin
        cmd.chunk_done = !is_end;
        cmd.msg_done   = is_end;
      end
      default:  cmd.gen = 1'b0;
    endcase
  end

endmodule

/* hw/rtl/cbframe_dp.sv */
// ----------------------------------------------------------------------------
// cbframe_dp
// Datapath: message state, chunk memory, crc, divider, character sources
// and the word packer with its output register.
// ----------------------------------------------------------------------------
module cbframe_dp import cbframe_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        mode,
  input  logic [15:0] task_id,
  input  logic [20:0] message_length,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] text_word,
  output logic [3:0]  char_count,
  output logic        line_end,
  output logic        message_end,
  output logic        last_of_run,
  output logic [1:0]  status,
  input  cmd_t        cmd,
  output stat_t       stat
);

  localparam int AW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int FW = $clog2(CHUNK_BYTES + 1);
  localparam int NW = 22;
  localparam int SH = NW + 6;
  localparam int unsigned MAX_LEN = 65535 * CHUNK_BYTES;
  // rounded-up reciprocal, exact for any numerator below 2**NW
  localparam logic [SH:0] RECIP =
    (SH+1)'(((64'd1 << SH) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));

  // captured item
  logic        i_mode;
  logic [15:0] i_task;
  logic [20:0] i_len;
  logic [7:0]  i_byte;

  // message state
  logic [3:0]    fmt_version;
  logic [FW-1:0] chunk_fill;
  logic [31:0]   chunk_crc, message_crc;
  logic [15:0]   chunk_number, chunk_total, current_task;
  logic [20:0]   bytes_left;
  logic          active;

  // chunk total
  logic [NW-1:0]  div_num;
  logic [NW+SH:0] div_prod;
  logic [15:0]    div_q;
  logic           div_pend;

  // chunk memory
  logic [7:0]    mem [CHUNK_BYTES];
  logic [7:0]    rd_data;
  logic [FW-1:0] rd_idx, rd_idx_next;

  // character sources
  logic [15:0] dec_val;
  logic [2:0]  dec_pos;
  logic        dec_started;
  logic [3:0]  dec_digit;
  logic [16:0] dec_sub;
  logic [2:0]  tag_idx, hex_idx;
  logic [31:0] hex_val;
  logic [15:0] b32_buf;
  logic [3:0]  b32_bits;
  logic [20:0] b32_shift;
  logic        b32_more, b32_load, b32_empty;

  logic [7:0]  ch;
  logic        char_ok, char_last, fire, out_free, line_last;

  // word packer
  logic [63:0] wbuf, word_new;
  logic [2:0]  wcnt;

  assign out_free = !result_valid || !result_stall;

  // ---------------- chunk total: ceil(len / CHUNK_BYTES) by reciprocal multiply
  assign div_prod = {{(SH+1){1'b0}}, div_num} * {{NW{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (cmd.start_msg) begin
      div_num <= NW'(i_len) + NW'(CHUNK_BYTES - 1);
    end
    if (div_pend) begin
      div_q <= div_prod[SH +: 16];
    end
  end

  // ---------------- item capture and message state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      i_mode <= mode;
      i_task <= task_id;
      i_len  <= message_length;
      i_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_version  <= VERSION_RESET;
      chunk_fill   <= '0;
      chunk_crc    <= CRC_ONES;
      message_crc  <= CRC_ONES;
      chunk_number <= '0;
      chunk_total  <= '0;
      bytes_left   <= '0;
      current_task <= '0;
      active       <= 1'b0;
      div_pend     <= 1'b0;
    end else begin
      div_pend <= cmd.start_msg;
      if (cfg_we) fmt_version <= cfg_wdata;
      if (cmd.start_msg) begin
        current_task <= i_task;
        chunk_number <= '0;
        chunk_fill   <= '0;
        chunk_crc    <= CRC_ONES;
        message_crc  <= CRC_ONES;
        bytes_left   <= i_len;
        active       <= 1'b1;
      end
      if (cmd.set_total) begin
        chunk_total <= (i_len == 21'd0) ? 16'd1 : div_q;
      end
      if (cmd.take_byte) begin
        if (32'(chunk_fill) < CHUNK_BYTES) chunk_fill <= chunk_fill + FW'(1);
        chunk_crc   <= crc_byte(chunk_crc, i_byte);
        message_crc <= crc_byte(message_crc, i_byte);
        if (bytes_left != 21'd0) bytes_left <= bytes_left - 21'd1;
      end
      if (cmd.chunk_done) begin
        chunk_fill   <= '0;
        chunk_crc    <= CRC_ONES;
        chunk_number <= chunk_number + 16'd1;
      end
      if (cmd.msg_done) active <= 1'b0;
    end
  end

  // ---------------- chunk memory, read data always follows rd_idx
  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.b32_init) begin
      rd_idx_next = '0;
    end else if (b32_load) begin
      rd_idx_next = rd_idx + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && (32'(chunk_fill) < CHUNK_BYTES)) begin
      mem[chunk_fill[AW-1:0]] <= i_byte;
    end
    rd_data <= mem[rd_idx_next[AW-1:0]];
  end

  // ---------------- character sources
  always_comb begin
    dec_digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, dec_val} >= dec_mul(dec_pos, 4'(k))) dec_digit = 4'(k);
    end
    dec_sub = dec_mul(dec_pos, dec_digit);
  end

  assign hex_val   = (cmd.is_end ? message_crc : chunk_crc) ^ CRC_ONES;
  assign b32_more  = (rd_idx < chunk_fill);
  assign b32_shift = {b32_buf, 5'd0} >> b32_bits;
  assign b32_load  = cmd.gen && (cmd.sel == SEL_B32) && (b32_bits < 4'd5) && b32_more;
  assign b32_empty = (b32_bits == 4'd0) && !b32_more;

  always_comb begin
    ch        = CH_COLON;
    char_ok   = 1'b1;
    char_last = 1'b1;
    case (cmd.sel)
      SEL_LT:    ch = CH_LT;
      SEL_SLASH: ch = CH_SLASH;
      SEL_COLON: ch = CH_COLON;
      SEL_GT:    ch = CH_GT;
      SEL_TAG: begin
        ch        = tag_char(tag_idx);
        char_last = (tag_idx == 3'd4);
      end
      SEL_HEX: begin
        ch        = hex_char(hex_val[{3'(3'd7 - hex_idx), 2'b00} +: 4]);
        char_last = (hex_idx == 3'd7);
      end
      SEL_DEC: begin
        ch        = CH_ZERO + {4'd0, dec_digit};
        char_ok   = (dec_digit != 4'd0) || dec_started || (dec_pos == 3'd0);
        char_last = (dec_pos == 3'd0);
      end
      SEL_B32: begin
        ch        = b32_char(b32_shift[4:0]);
        char_ok   = (b32_bits >= 4'd5) || (!b32_more && (b32_bits != 4'd0));
        char_last = !b32_more && (b32_bits <= 4'd5);
      end
      default: ch = CH_COLON;
    endcase
  end

  assign fire      = cmd.gen && char_ok && out_free;
  assign line_last = (cmd.sel == SEL_GT);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_idx     <= '0;
      hex_idx     <= '0;
      dec_pos     <= '0;
      dec_started <= 1'b0;
      b32_bits    <= '0;
      rd_idx      <= '0;
    end else begin
      rd_idx <= rd_idx_next;
      if (fire && (cmd.sel == SEL_TAG)) tag_idx <= char_last ? 3'd0 : tag_idx + 3'd1;
      if (fire && (cmd.sel == SEL_HEX)) hex_idx <= hex_idx + 3'd1;
      if (cmd.dec_load) begin
        dec_pos     <= 3'd4;
        dec_started <= 1'b0;
      end else if (cmd.gen && (cmd.sel == SEL_DEC) && (fire || !char_ok)) begin
        // leading zeros advance without a character
        dec_pos     <= dec_pos - 3'd1;
        dec_started <= dec_started || (dec_digit != 4'd0);
      end
      if (cmd.b32_init) begin
        b32_bits <= '0;
      end else if (b32_load) begin
        b32_bits <= b32_bits + 4'd8;
      end else if (fire && (cmd.sel == SEL_B32)) begin
        b32_bits <= (b32_bits >= 4'd5) ? b32_bits - 4'd5 : 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_load) begin
      case (cmd.dec_src)
        DSRC_VER:  dec_val <= {12'd0, fmt_version};
        DSRC_TASK: dec_val <= current_task;
        DSRC_IDX:  dec_val <= chunk_number;
        DSRC_TOT:  dec_val <= chunk_total;
        default:   dec_val <= chunk_total;
      endcase
    end else if (cmd.gen && (cmd.sel == SEL_DEC) && (fire || !char_ok)) begin
      dec_val <= dec_val - dec_sub[15:0];
    end
    if (b32_load) b32_buf <= {b32_buf[7:0], rd_data};
  end

  // ---------------- word packer and output register
  assign word_new = wbuf | ({56'd0, ch} << {3'(3'd7 - wcnt), 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      wbuf         <= '0;
      wcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        if ((wcnt == 3'd7) || line_last) begin
          wbuf <= '0;
          wcnt <= '0;
        end else begin
          wbuf <= word_new;
          wcnt <= wcnt + 3'd1;
        end
      end
      if ((fire && ((wcnt == 3'd7) || line_last)) || cmd.err_push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_push) begin
      text_word   <= '0;
      char_count  <= '0;
      line_end    <= 1'b0;
      message_end <= 1'b0;
      last_of_run <= 1'b1;
      status      <= cmd.err_code;
    end else if (fire && ((wcnt == 3'd7) || line_last)) begin
      text_word   <= word_new;
      char_count  <= {1'b0, wcnt} + 4'd1;
      line_end    <= line_last;
      message_end <= line_last && cmd.is_end;
      last_of_run <= line_last && cmd.run_last;
      status      <= ST_OK;
    end
  end

  // ---------------- status to the sequencer
  always_comb begin
    stat.mode       = i_mode;
    stat.bad_start  = (i_task == 16'd0) || (32'(i_len) > MAX_LEN);
    stat.active     = active;
    stat.div_done   = !div_pend;
    stat.need_line  = (32'(chunk_fill) >= CHUNK_BYTES) || (bytes_left == 21'd0);
    stat.last_byte  = (bytes_left == 21'd0);
    stat.len_zero   = (i_len == 21'd0);
    stat.out_free   = out_free;
    stat.field_done = (fire && char_last) ||
                      (cmd.gen && (cmd.sel == SEL_B32) && b32_empty);
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chunk line framer: sends start and data byte
// transactions, predicts every text word with crc-32 and base32 computed
// here, and compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import cbframe_pkg::*;

  localparam int CHUNK     = 32;
  localparam int MAX_LEN   = 2097120;
  localparam int STALL_CAP = 20000;
  localparam int SETTLE    = 200;

  typedef struct {
    logic [63:0] text;
    logic [3:0]  cnt;
    logic        le;
    logic        me;
    logic        lr;
    logic [1:0]  st;
  } word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        item_valid;
  logic        item_stall;
  logic        mode;
  logic [15:0] task_id;
  logic [20:0] message_length;
  logic [7:0]  data_byte;
  logic        result_valid;
  logic        result_stall;
  logic [63:0] text_word;
  logic [3:0]  char_count;
  logic        line_end;
  logic        message_end;
  logic        last_of_run;
  logic [1:0]  status;

  crc32_base32_chunk_line_framer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item_stall(item_stall), .mode(mode),
    .task_id(task_id), .message_length(message_length), .data_byte(data_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .text_word(text_word), .char_count(char_count), .line_end(line_end),
    .message_end(message_end), .last_of_run(last_of_run), .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // framer state as predicted
  logic [3:0]  fmt_ver;
  logic [7:0]  chunk_bytes [CHUNK];
  int          fill;
  logic [31:0] chunk_crc, msg_crc;
  logic [15:0] chunk_idx, chunk_cnt;
  logic [20:0] remaining;
  logic [15:0] cur_task;
  logic        in_message;

  logic [7:0] line_chars[$];
  word_t      run_words[$];
  word_t      pending_words[$];

  int errors;
  int n_items;
  int tx_idle_pct;
  int rx_idle_pct;
  int quiet_cycles;

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  function automatic void put_dec(int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(8'(48 + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) line_chars.push_back(digits[i]);
  endfunction

  function automatic void put_hex(logic [31:0] v);
    logic [3:0] n;
    for (int s = 7; s >= 0; s--) begin
      n = v[s*4 +: 4];
      line_chars.push_back(n < 10 ? 8'(48 + n) : 8'(55 + n));
    end
  endfunction

  function automatic void put_tag();
    // frame tag letters
    line_chars.push_back(8'h52);
    line_chars.push_back(8'h49);
    line_chars.push_back(8'h42);
    line_chars.push_back(8'h33);
    line_chars.push_back(8'h32);
  endfunction

  function automatic logic [7:0] b32_letter(logic [4:0] n);
    return n < 26 ? 8'(65 + n) : 8'(24 + n);
  endfunction

  function automatic void put_b32();
    logic [15:0] acc;
    int bits;
    acc = '0;
    bits = 0;
    for (int i = 0; i < fill; i++) begin
      acc = {acc[7:0], chunk_bytes[i]};
      bits += 8;
      while (bits >= 5) begin
        line_chars.push_back(b32_letter(5'(acc >> (bits - 5))));
        bits -= 5;
      end
    end
    if (bits > 0) line_chars.push_back(b32_letter(5'(acc << (5 - bits))));
  endfunction

  function automatic void cut_line(logic is_end);
    word_t w;
    int pos, n;
    pos = 0;
    while (pos < line_chars.size()) begin
      n = line_chars.size() - pos;
      if (n > 8) n = 8;
      w.text = '0;
      for (int k = 0; k < n; k++) w.text[63 - 8*k -: 8] = line_chars[pos + k];
      pos += n;
      w.cnt = 4'(n);
      w.le = pos >= line_chars.size();
      w.me = is_end && w.le;
      w.lr = 1'b0;
      w.st = ST_OK;
      run_words.push_back(w);
    end
    line_chars.delete();
  endfunction

  function automatic void chunk_line();
    line_chars.push_back("<");
    put_tag();
    line_chars.push_back(":");
    put_dec(fmt_ver);
    line_chars.push_back(":");
    put_dec(cur_task);
    line_chars.push_back(":");
    put_dec(chunk_idx);
    line_chars.push_back(":");
    put_dec(chunk_cnt);
    line_chars.push_back(":");
    put_hex(~chunk_crc);
    line_chars.push_back(":");
    put_b32();
    line_chars.push_back(">");
    cut_line(1'b0);
    fill = 0;
    chunk_crc = CRC_ONES;
    chunk_idx = chunk_idx + 16'd1;
  endfunction

  function automatic void closing_line();
    line_chars.push_back("<");
    line_chars.push_back("/");
    put_tag();
    line_chars.push_back(":");
    put_dec(fmt_ver);
    line_chars.push_back(":");
    put_dec(cur_task);
    line_chars.push_back(":");
    put_hex(~msg_crc);
    line_chars.push_back(">");
    cut_line(1'b1);
    in_message = 1'b0;
  endfunction

  function automatic void reject(logic [1:0] code);
    word_t w;
    w.text = '0;
    w.cnt = '0;
    w.le = 1'b0;
    w.me = 1'b0;
    w.lr = 1'b0;
    w.st = code;
    run_words.push_back(w);
  endfunction

  // expected text words caused by one accepted transaction
  function automatic void frame_item(logic m, logic [15:0] t, logic [20:0] l, logic [7:0] d);
    int unsigned total;
    run_words.delete();
    if (m == MODE_START) begin
      total = (l == 0) ? 1 : (int'(l) + CHUNK - 1) / CHUNK;
      if (t == 0 || total > 65535) reject(ST_BAD_START);
      else begin
        cur_task = t;
        chunk_cnt = 16'(total);
        chunk_idx = '0;
        fill = 0;
        chunk_crc = CRC_ONES;
        msg_crc = CRC_ONES;
        remaining = l;
        in_message = 1'b1;
        if (l == 0) begin
          chunk_line();
          closing_line();
        end
      end
    end else if (!in_message) begin
      reject(ST_STRAY);
    end else begin
      chunk_bytes[fill] = d;
      fill++;
      chunk_crc = crc_step(chunk_crc, d);
      msg_crc = crc_step(msg_crc, d);
      if (remaining > 0) remaining--;
      if (fill >= CHUNK || remaining == 0) chunk_line();
      if (remaining == 0) closing_line();
    end
    if (run_words.size() > 0) run_words[run_words.size() - 1].lr = 1'b1;
    foreach (run_words[i]) pending_words.push_back(run_words[i]);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_item(logic m, logic [15:0] t, logic [20:0] l, logic [7:0] d);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    task_id <= t;
    message_length <= l;
    data_byte <= d;
    do @(posedge clk); while (item_stall);
    frame_item(m, t, l, d);
    n_items++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_version(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_ver = v;
  endtask

  task automatic send_message(logic [15:0] t, int len);
    send_item(MODE_START, t, 21'(len), 8'($urandom));
    for (int i = 0; i < len; i++)
      send_item(MODE_DATA, 16'($urandom), 21'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(MODE_DATA, 16'hFFFF, 21'h1FFFFF, 8'hFF);      // stray byte
    send_item(MODE_START, 16'd0, 21'd5, 8'h00);              // zero task id
    send_item(MODE_START, 16'd7, 21'(MAX_LEN + 1), 8'h00);   // oversized
    send_item(MODE_START, 16'd9, 21'h1FFFFF, 8'h00);
    send_item(MODE_START, 16'hFFFF, 21'd0, 8'h00);           // zero length
    send_item(MODE_START, 16'd1, 21'd0, 8'h00);
    send_item(MODE_START, 16'd1, 21'd1, 8'h00);
    send_item(MODE_DATA, 16'd0, 21'd0, 8'hFF);
    // long message abandoned by a new start
    send_item(MODE_START, 16'hFFFF, 21'(MAX_LEN), 8'h00);
    send_item(MODE_DATA, 16'd0, 21'd0, 8'hA5);
    send_message(16'd12345, 5);
    send_item(MODE_DATA, 16'd0, 21'd0, 8'h00);
  endtask

  task automatic test_config();
    set_version(4'd0);
    send_message(16'd42, 3);
    set_version(4'd15);
    send_message(16'd65535, 0);
    send_message(16'd100, 2);
    set_version(4'd10);
    send_message(16'd3, 1);
    set_version(4'd9);
  endtask

  task automatic test_random(int target, bit hold_off);
    int r, len, goal;
    goal = n_items + target;
    while (n_items < goal) begin
      r = $urandom_range(99);
      if (hold_off && n_items > goal - target / 2) begin
        hold_off = 0;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
      end
      if (r < 80) begin
        len = ($urandom_range(9) < 8) ? $urandom_range(0, 40) : $urandom_range(41, 100);
        if (len > goal - n_items - 1) len = goal - n_items - 1;
        send_message(16'($urandom_range(1, 65535)), len);
      end else if (r < 85) begin
        send_item(MODE_DATA, 16'($urandom), 21'($urandom), 8'($urandom));
      end else if (r < 90) begin
        send_item(MODE_START, 16'd0, 21'($urandom), 8'($urandom));
      end else if (r < 94) begin
        send_item(MODE_START, 16'($urandom_range(1, 65535)),
                  21'($urandom_range(MAX_LEN + 1, 21'h1FFFFF)), 8'($urandom));
      end else begin
        // truncated message, the next start abandons it
        send_item(MODE_START, 16'($urandom_range(1, 65535)),
                  21'($urandom_range(MAX_LEN, 200)), 8'($urandom));
        repeat ($urandom_range(0, 40))
          send_item(MODE_DATA, 16'($urandom), 21'($urandom), 8'($urandom));
        send_message(16'($urandom_range(1, 65535)), $urandom_range(0, 33));
      end
    end
  endtask

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk) begin
    word_t w;
    if (!rst && result_valid && !result_stall) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", text_word, 64'd0);
      end else begin
        w = pending_words.pop_front();
        if (text_word !== w.text) report("text_word", text_word, w.text);
        if (char_count !== w.cnt) report("char_count", 64'(char_count), 64'(w.cnt));
        if (line_end !== w.le) report("line_end", 64'(line_end), 64'(w.le));
        if (message_end !== w.me) report("message_end", 64'(message_end), 64'(w.me));
        if (last_of_run !== w.lr) report("last_of_run", 64'(last_of_run), 64'(w.lr));
        if (status !== w.st) report("status", 64'(status), 64'(w.st));
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_CAP) begin
      $display("[crc32_base32_chunk_line_framer] ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    n_items = 0;
    quiet_cycles = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 73;
    fmt_ver = VERSION_RESET;
    fill = 0;
    chunk_crc = CRC_ONES;
    msg_crc = CRC_ONES;
    chunk_idx = '0;
    chunk_cnt = '0;
    remaining = '0;
    cur_task = '0;
    in_message = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    item_valid <= 1'b0;
    mode <= 1'b0;
    task_id <= '0;
    message_length <= '0;
    data_byte <= '0;
    result_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config();
    test_random(60, 1'b0);
    tx_idle_pct = 73;
    rx_idle_pct = 10;
    set_version(4'd5);
    test_random(60, 1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_version(4'd1);
    test_random(60, 1'b0);
    drain();

    if (errors == 0) $display("[crc32_base32_chunk_line_framer] OK");
    else $display("[crc32_base32_chunk_line_framer] ERROR");
    $finish;
  end

endmodule
